// ===== rtl/gmns_pkg.sv =====
package gmns_pkg;

	localparam int DIM_W = 9;
	localparam int PIX_W = 8;
	localparam int COORD_W = 8;
	localparam int PTR_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_DIM = 256;
	localparam int DEF_MAP_DEPTH = 65536;

	// x * width, and the quotient that comes out of the divider
	localparam int PROD_W = COORD_W + DIM_W;
	localparam int DIV_CNT_W = $clog2(PROD_W);
	// width * height and row * width + column
	localparam int SIZE_W = 2 * DIM_W;
	localparam int SUM_W = PIX_W + 2;

	// floor(s / 3) == (s * 683) >> 11 for every s up to 3 * 255
	localparam int DIV3_MUL_W = 2 * SUM_W;
	localparam logic [SUM_W-1:0] DIV3_MUL = SUM_W'(683);
	localparam int DIV3_SHIFT = 11;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] dw;
		logic [DIM_W-1:0] dh;
	} dims_t;

	typedef struct packed {
		logic cmd;
		logic [PIX_W-1:0] gray;
		logic [COORD_W-1:0] dst_x;
		logic [COORD_W-1:0] dst_y;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// zero acts as one, anything above the largest size acts as the largest size
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (32'(v) > MAX_DIM)
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

// ===== rtl/gmns_in_if.sv =====
interface gmns_in_if import gmns_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic [COORD_W-1:0] dst_x;
	logic [COORD_W-1:0] dst_y;

	modport source(output valid, cmd, red, green, blue, dst_x, dst_y, input ready);
	modport sink(input valid, cmd, red, green, blue, dst_x, dst_y, output ready);
endinterface

// ===== rtl/gmns_out_if.sv =====
interface gmns_out_if import gmns_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] gray_value;

	modport source(output valid, gray_value, input ready);
	modport sink(input valid, gray_value, output ready);
endinterface

// ===== rtl/gmns_cfg_if.sv =====
interface gmns_cfg_if import gmns_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/gray_map_nearest_scaler_top.sv =====
// channel  dir  words                             fields
// item     in   pixel write or scaled read        cmd, red, green, blue, dst_x, dst_y
// result   out  one word per scaled read          gray_value
// cfg      in   register write, always ready      index, data
//
// a pixel write is stored in the map as it leaves the queue; a scaled read holds the back end
// while the two 17-step serial dividers scale x and y side by side
// the four-word queue takes items while the back end works; ready drops only when full
// a waiting result sits in its output register while the back end goes on
// reset clears the load pointer and sets all sizes to 1; map contents stay unknown
// the user must keep the map depth a power of two, which the block does not enforce; map addresses wrap at it
module gray_map_nearest_scaler_top import gmns_pkg::*; #(
	parameter int MAP_DEPTH = DEF_MAP_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	gmns_in_if.sink    item,
	gmns_out_if.source result,
	gmns_cfg_if.sink   cfg
);

	localparam int ADDR_W = $clog2(MAP_DEPTH);
	localparam int ENT_W = $bits(qent_t);
	localparam int QW = ADDR_W + ENT_W;

	logic [DIM_W-1:0] src_width_q;
	logic [DIM_W-1:0] src_height_q;
	logic [DIM_W-1:0] dst_width_q;
	logic [DIM_W-1:0] dst_height_q;
	dims_t dims;

	logic q_push;
	logic q_pop;
	qent_t push_ent;
	logic [ADDR_W-1:0] push_addr;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;
	qstat_t q_stat;
	qent_t pop_ent;
	logic [ADDR_W-1:0] pop_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= DIM_W'(1);
			src_height_q <= DIM_W'(1);
			dst_width_q <= DIM_W'(1);
			dst_height_q <= DIM_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SRC_WIDTH: src_width_q <= cfg.data;
				REG_SRC_HEIGHT: src_height_q <= cfg.data;
				REG_DST_WIDTH: dst_width_q <= cfg.data;
				REG_DST_HEIGHT: dst_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign dims.sw = eff_dim(src_width_q);
	assign dims.sh = eff_dim(src_height_q);
	assign dims.dw = eff_dim(dst_width_q);
	assign dims.dh = eff_dim(dst_height_q);

	gmns_front #(
		.ADDR_W (ADDR_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.dims      (dims),
		.qstat     (q_stat),
		.push      (q_push),
		.push_ent  (push_ent),
		.push_addr (push_addr)
	);

	assign q_din = {push_addr, push_ent};

	gmns_queue #(
		.W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.stat   (q_stat)
	);

	assign pop_addr = q_dout[QW-1 -: ADDR_W];
	assign pop_ent = qent_t'(q_dout[ENT_W-1:0]);

	gmns_back #(
		.MAP_DEPTH (MAP_DEPTH),
		.ADDR_W    (ADDR_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.dims     (dims),
		.qstat    (q_stat),
		.pop_ent  (pop_ent),
		.pop_addr (pop_addr),
		.pop      (q_pop),
		.result   (result)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("back end popped an empty queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |=> !q_stat.empty)
		else $error("queue empty after a push without a pop");

endmodule

// ===== rtl/gmns_queue.sv =====
module gmns_queue import gmns_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output qstat_t       stat
);

	logic [W-1:0] slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0] cnt_q;

	assign stat.full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign dout = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= din;
	end

endmodule

// ===== rtl/gmns_front.sv =====
module gmns_front import gmns_pkg::*; #(
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	gmns_in_if.sink           item,
	input  dims_t             dims,
	input  qstat_t            qstat,
	output logic              push,
	output qent_t             push_ent,
	output logic [ADDR_W-1:0] push_addr
);

	logic [PTR_W-1:0] ptr_q;
	logic [SIZE_W-1:0] size;
	logic [PTR_W-1:0] idx;
	logic [PTR_W:0] idx_inc;
	logic [SUM_W-1:0] sum;
	logic [DIV3_MUL_W-1:0] third;

	assign item.ready = !qstat.full;
	assign push = item.valid && item.ready;

	assign size = SIZE_W'(dims.sw) * SIZE_W'(dims.sh);
	// a pointer left past the map by a size change restarts at entry 0
	assign idx = (SIZE_W'(ptr_q) < size) ? ptr_q : '0;
	assign idx_inc = (PTR_W+1)'(idx) + 1'b1;

	assign sum = SUM_W'(item.red) + SUM_W'(item.green) + SUM_W'(item.blue);
	assign third = DIV3_MUL_W'(sum) * DIV3_MUL_W'(DIV3_MUL);

	assign push_ent.cmd = item.cmd;
	assign push_ent.gray = third[DIV3_SHIFT +: PIX_W];
	assign push_ent.dst_x = item.dst_x;
	assign push_ent.dst_y = item.dst_y;
	assign push_addr = ADDR_W'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (push && item.cmd == CMD_WRITE) begin
			ptr_q <= (SIZE_W'(idx_inc) >= size) ? '0 : idx_inc[PTR_W-1:0];
		end
	end

endmodule

// ===== rtl/gmns_div.sv =====
module gmns_div import gmns_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DIM_W-1:0]  divisor,
	output logic              busy,
	output logic [PROD_W-1:0] quotient
);

	logic busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0] n_q;
	logic [DIM_W-1:0] r_q;
	logic [DIM_W-1:0] d_q;
	logic [DIM_W:0] rem_sh;
	logic [DIM_W:0] rem_sub;
	logic ge;

	// restoring division, one quotient bit per cycle shifted in behind the dividend
	assign rem_sh = {r_q, n_q[PROD_W-1]};
	assign ge = (rem_sh >= {1'b0, d_q});
	assign rem_sub = rem_sh - {1'b0, d_q};

	assign busy = busy_q;
	assign quotient = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(PROD_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			n_q <= {n_q[PROD_W-2:0], ge};
			r_q <= ge ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
		end
	end

endmodule

// ===== rtl/gmns_back.sv =====
module gmns_back import gmns_pkg::*; #(
	parameter int MAP_DEPTH = DEF_MAP_DEPTH,
	parameter int ADDR_W = $clog2(MAP_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dims_t             dims,
	input  qstat_t            qstat,
	input  qent_t             pop_ent,
	input  logic [ADDR_W-1:0] pop_addr,
	output logic              pop,
	gmns_out_if.source        result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_CLAMP = 3'd3;
	localparam logic [2:0] S_ADDR = 3'd4;
	localparam logic [2:0] S_RD = 3'd5;
	localparam logic [2:0] S_DATA = 3'd6;

	logic [2:0] state_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [DIM_W-1:0] sx_q;
	logic [DIM_W-1:0] sy_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PIX_W-1:0] rd_q;
	logic [PIX_W-1:0] out_q;
	logic out_valid_q;

	logic [PIX_W-1:0] map_mem [MAP_DEPTH];

	logic div_start;
	logic [PROD_W-1:0] px;
	logic [PROD_W-1:0] py;
	logic x_busy;
	logic y_busy;
	logic [PROD_W-1:0] qx;
	logic [PROD_W-1:0] qy;
	logic mem_we;
	logic out_load;
	logic [SIZE_W-1:0] addr_full;

	assign pop = (state_q == S_IDLE) && !qstat.empty;
	assign mem_we = pop && (pop_ent.cmd == CMD_WRITE);
	assign div_start = (state_q == S_START);
	assign px = PROD_W'(x_q) * PROD_W'(dims.sw);
	assign py = PROD_W'(y_q) * PROD_W'(dims.sh);
	assign addr_full = SIZE_W'(sy_q) * SIZE_W'(dims.sw) + SIZE_W'(sx_q);
	assign out_load = (state_q == S_DATA) && (!out_valid_q || result.ready);

	assign result.valid = out_valid_q;
	assign result.gray_value = out_q;

	gmns_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (px),
		.divisor  (dims.dw),
		.busy     (x_busy),
		.quotient (qx)
	);

	gmns_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (py),
		.divisor  (dims.dh),
		.busy     (y_busy),
		.quotient (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop && pop_ent.cmd == CMD_READ)
						state_q <= S_START;
				end
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (!x_busy && !y_busy)
						state_q <= S_CLAMP;
				end
				S_CLAMP: state_q <= S_ADDR;
				S_ADDR: state_q <= S_RD;
				S_RD: state_q <= S_DATA;
				S_DATA: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q <= pop_ent.dst_x;
			y_q <= pop_ent.dst_y;
		end
		// a coordinate that lands on or past the edge sticks to the last pixel
		if (state_q == S_CLAMP) begin
			sx_q <= (qx >= PROD_W'(dims.sw)) ? dims.sw - 1'b1 : qx[DIM_W-1:0];
			sy_q <= (qy >= PROD_W'(dims.sh)) ? dims.sh - 1'b1 : qy[DIM_W-1:0];
		end
		if (state_q == S_ADDR)
			addr_q <= ADDR_W'(addr_full);
		if (out_load)
			out_q <= rd_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[pop_addr] <= pop_ent.gray;
		rd_q <= map_mem[addr_q];
	end

endmodule
